[design/usbdp_pkg.sv]
// Package for the USB data packetizer: codes, queue entry type, CRC-16 step.
// No dependencies; compiled first.
package usbdp_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [6:0]  MAX_PACKET_RST = 7'd8;
	localparam logic [7:0]  DATA0_PID_RST = 8'd195;
	localparam logic [7:0]  DATA1_PID_RST = 8'd75;
	localparam logic [6:0]  PACKET_LIMIT = 7'd64;

	typedef enum logic [1:0] {
		FUNC_BYTE  = 2'd0,
		FUNC_RXPID = 2'd1,
		FUNC_EMPTY = 2'd2
	} usbdp_func_t;

	typedef enum logic [1:0] {
		KIND_PID  = 2'd0,
		KIND_DATA = 2'd1,
		KIND_CRC  = 2'd2
	} usbdp_kind_t;

	typedef enum logic [1:0] {
		REG_MAX_PACKET = 2'd0,
		REG_DATA0_PID  = 2'd1,
		REG_DATA1_PID  = 2'd2
	} usbdp_reg_t;

	// one-hot positions of the output steps of one queue entry
	localparam int unsigned STEP_PID    = 0;
	localparam int unsigned STEP_DATA   = 1;
	localparam int unsigned STEP_CRC_LO = 2;
	localparam int unsigned STEP_CRC_HI = 3;
	localparam int unsigned STEP_ZPID   = 4;
	localparam int unsigned STEP_ZLO    = 5;
	localparam int unsigned STEP_ZHI    = 6;
	localparam int unsigned NUM_STEPS   = 7;

	typedef struct packed {
		logic       open;
		logic [7:0] pid_a;
		logic       data_en;
		logic [7:0] data;
		logic       close;
		logic       zlp;
		logic [7:0] pid_b;
	} usbdp_cmd_t;

	typedef struct packed {
		logic [6:0] max_packet;
		logic [7:0] data0_pid;
		logic [7:0] data1_pid;
	} usbdp_cfg_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ b[i]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[design/usbdp_if.sv]
// Valid/ready channel interfaces for the input items and the output bytes.
// Standalone; used by the front, back and top-level modules.
interface usbdp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic       last_of_transfer;
	logic       received_data1;

	modport source(output valid, func, data_byte, last_of_transfer, received_data1,
		input ready);
	modport sink(input valid, func, data_byte, last_of_transfer, received_data1,
		output ready);
endinterface

interface usbdp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] byte_kind;
	logic       end_of_packet;

	modport source(output valid, out_byte, byte_kind, end_of_packet, input ready);
	modport sink(input valid, out_byte, byte_kind, end_of_packet, output ready);
endinterface

[design/usbdp_front.sv]
// Front end: accepts input items, tracks packet fill and data toggle, and turns
// each byte or empty item into one queue entry. Depends on usbdp_pkg, usbdp_in_if.
module usbdp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	usbdp_in_if.sink             in_ch,
	input  usbdp_pkg::usbdp_cfg_t cfg,
	output logic                 push_valid,
	input  logic                 push_ready,
	output usbdp_pkg::usbdp_cmd_t push_data
);
	import usbdp_pkg::*;

	logic [6:0] bytes_q;
	logic       toggle_q;
	logic [6:0] limit;
	logic [6:0] bytes_inc;
	logic       full;
	logic       accept;
	logic       t1;
	logic       is_byte;
	logic       is_empty;

	assign is_byte  = in_ch.func == FUNC_BYTE;
	assign is_empty = in_ch.func == FUNC_EMPTY;

	always_comb begin
		if (cfg.max_packet == 7'd0) begin
			limit = 7'd1;
		end else if (cfg.max_packet > PACKET_LIMIT) begin
			limit = PACKET_LIMIT;
		end else begin
			limit = cfg.max_packet;
		end
	end

	assign bytes_inc = bytes_q + 7'd1;
	assign full      = bytes_inc >= limit;

	always_comb begin
		push_data = '0;
		t1 = toggle_q;
		if (is_byte) begin
			push_data.open    = bytes_q == 7'd0;
			push_data.pid_a   = toggle_q ? cfg.data1_pid : cfg.data0_pid;
			t1                = push_data.open ? ~toggle_q : toggle_q;
			push_data.data_en = 1'b1;
			push_data.data    = in_ch.data_byte;
			push_data.close   = full | in_ch.last_of_transfer;
			push_data.zlp     = full & in_ch.last_of_transfer;
		end else begin
			push_data.close = bytes_q != 7'd0;
			push_data.zlp   = 1'b1;
		end
		push_data.pid_b = t1 ? cfg.data1_pid : cfg.data0_pid;
	end

	assign in_ch.ready = push_ready;
	assign push_valid  = in_ch.valid & (is_byte | is_empty);
	assign accept      = in_ch.valid & in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q  <= '0;
			toggle_q <= 1'b0;
		end else if (accept) begin
			case (in_ch.func)
				FUNC_BYTE: begin
					bytes_q  <= (full | in_ch.last_of_transfer) ? 7'd0 : bytes_inc;
					toggle_q <= push_data.zlp ? ~t1 : t1;
				end
				FUNC_RXPID: begin
					toggle_q <= ~in_ch.received_data1;
				end
				FUNC_EMPTY: begin
					bytes_q  <= '0;
					toggle_q <= ~toggle_q;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[design/usbdp_fifo.sv]
// Short flip-flop queue of packet commands between front and back end.
// Depends on usbdp_pkg for the entry type.
module usbdp_fifo #(
	parameter int unsigned DEPTH = usbdp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  usbdp_pkg::usbdp_cmd_t push_data,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output usbdp_pkg::usbdp_cmd_t pop_data
);
	import usbdp_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	usbdp_cmd_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/usbdp_back.sv]
// Back end: walks each queued command through its wire bytes, keeps the
// running CRC-16 and drives the output register. Depends on usbdp_pkg, usbdp_out_if.
module usbdp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  usbdp_pkg::usbdp_cmd_t pop_data,
	usbdp_out_if.source           out_ch
);
	import usbdp_pkg::*;

	usbdp_cmd_t           cur_q;
	logic [NUM_STEPS-1:0] mask_q;
	logic [15:0]          crc_q;
	logic                 ov_q;
	logic [7:0]           byte_q;
	usbdp_kind_t          kind_q;
	logic                 eop_q;

	logic [NUM_STEPS-1:0] lsb;
	logic [NUM_STEPS-1:0] mask_after;
	logic [NUM_STEPS-1:0] load_mask;
	logic                 emit;
	logic                 load;
	logic [7:0]           nxt_byte;
	usbdp_kind_t          nxt_kind;
	logic                 nxt_eop;
	logic [15:0]          nxt_crc;
	logic [15:0]          crc_inv;

	assign emit       = (mask_q != '0) & (~ov_q | out_ch.ready);
	assign lsb        = mask_q & (~mask_q + 1'b1);
	assign mask_after = emit ? (mask_q & ~lsb) : mask_q;
	assign load       = pop_valid & (mask_after == '0);
	assign pop_ready  = load;
	assign crc_inv    = ~crc_q;

	always_comb begin
		load_mask = '0;
		load_mask[STEP_PID]    = pop_data.open;
		load_mask[STEP_DATA]   = pop_data.data_en;
		load_mask[STEP_CRC_LO] = pop_data.close;
		load_mask[STEP_CRC_HI] = pop_data.close;
		load_mask[STEP_ZPID]   = pop_data.zlp;
		load_mask[STEP_ZLO]    = pop_data.zlp;
		load_mask[STEP_ZHI]    = pop_data.zlp;
	end

	always_comb begin
		nxt_byte = 8'h00;
		nxt_kind = KIND_CRC;
		nxt_eop  = 1'b0;
		nxt_crc  = crc_q;
		if (lsb[STEP_PID]) begin
			nxt_byte = cur_q.pid_a;
			nxt_kind = KIND_PID;
			nxt_crc  = CRC_INIT;
		end else if (lsb[STEP_DATA]) begin
			nxt_byte = cur_q.data;
			nxt_kind = KIND_DATA;
			nxt_crc  = crc_byte(crc_q, cur_q.data);
		end else if (lsb[STEP_CRC_LO]) begin
			nxt_byte = crc_inv[7:0];
		end else if (lsb[STEP_CRC_HI]) begin
			nxt_byte = crc_inv[15:8];
			nxt_eop  = 1'b1;
			nxt_crc  = CRC_INIT;
		end else if (lsb[STEP_ZPID]) begin
			nxt_byte = cur_q.pid_b;
			nxt_kind = KIND_PID;
		end else if (lsb[STEP_ZHI]) begin
			nxt_eop = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			crc_q  <= CRC_INIT;
			ov_q   <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= load_mask;
			end else begin
				mask_q <= mask_after;
			end
			if (emit) begin
				crc_q <= nxt_crc;
				ov_q  <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= pop_data;
		end
		if (emit) begin
			byte_q <= nxt_byte;
			kind_q <= nxt_kind;
			eop_q  <= nxt_eop;
		end
	end

	assign out_ch.valid         = ov_q;
	assign out_ch.out_byte      = byte_q;
	assign out_ch.byte_kind     = kind_q;
	assign out_ch.end_of_packet = eop_q;

endmodule

[design/usb_data_packetizer_crc16.sv]
// Top level of the USB data packetizer with CRC-16: register port, front end,
// command queue and back end. Depends on usbdp_pkg, usbdp_if and the submodules.
//
// Usage:
//   in_ch carries one item per transfer: a payload byte (func 0, with
//   last_of_transfer on the final byte), a received data PID (func 1, sets
//   the toggle, no output) or an empty transfer (func 2).
//   out_ch carries one wire byte per transfer: PID, payload and CRC bytes,
//   with end_of_packet on the second CRC byte of each packet.
//   The APB port holds max_packet (0x0), data0_pid (0x4), data1_pid (0x8);
//   write them only while the block is idle.
// Timing:
//   An item is taken in the cycle it arrives unless the command queue is
//   full. With the back end idle its first byte passes through the queue, the
//   back end's command register and the output register before it is valid on
//   out_ch. Each item expands into zero to seven bytes; the back end sends one
//   byte per cycle while out_ch is ready, so the output port sets throughput:
//   one wire byte per mid-packet byte, up to seven for a byte ending a full packet.
// Reset clears the queue, the output register, the fill count and the
// toggle (first packet DATA0), and loads the register reset values.
// When out_ch stalls the output byte holds; the queue fills, then in_ch.ready drops.
module usb_data_packetizer_crc16 #(
	parameter int unsigned QUEUE_DEPTH = usbdp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	usbdp_in_if.sink    in_ch,
	usbdp_out_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import usbdp_pkg::*;

	usbdp_cfg_t cfg_q;
	usbdp_cmd_t push_data;
	usbdp_cmd_t pop_data;
	logic       push_valid;
	logic       push_ready;
	logic       pop_valid;
	logic       pop_ready;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_packet <= MAX_PACKET_RST;
			cfg_q.data0_pid  <= DATA0_PID_RST;
			cfg_q.data1_pid  <= DATA1_PID_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MAX_PACKET: cfg_q.max_packet <= pwdata[6:0];
				REG_DATA0_PID:  cfg_q.data0_pid  <= pwdata[7:0];
				REG_DATA1_PID:  cfg_q.data1_pid  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MAX_PACKET: prdata = {25'd0, cfg_q.max_packet};
			REG_DATA0_PID:  prdata = {24'd0, cfg_q.data0_pid};
			REG_DATA1_PID:  prdata = {24'd0, cfg_q.data1_pid};
			default:        prdata = '0;
		endcase
	end

	usbdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	usbdp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	usbdp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_ch    (out_ch)
	);

endmodule

[tb/usbdp_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the USB data packetizer: watches both channels and the APB port.
// Needs usbdp_pkg and usbdp_if.
module usbdp_checker (
	input  logic        clk,
	input  logic        arst_n,
	usbdp_in_if         in_ch,
	usbdp_out_if        out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending_count
);
	import usbdp_pkg::*;

	typedef struct packed {
		logic [7:0]  value;
		usbdp_kind_t kind;
		logic        eop;
	} wire_byte_t;

	wire_byte_t  wire_bytes_q[$];

	logic [6:0]  max_pkt;
	logic [7:0]  pid0;
	logic [7:0]  pid1;
	logic [15:0] crc;
	logic [6:0]  fill;
	logic        next_data1;

	function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = c;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

	function automatic void emit(input logic [7:0] v, input usbdp_kind_t k, input logic eop);
		wire_byte_t e;
		e.value = v;
		e.kind = k;
		e.eop = eop;
		wire_bytes_q.push_back(e);
	endfunction

	function automatic void open_packet();
		emit(next_data1 ? pid1 : pid0, KIND_PID, 1'b0);
		next_data1 = ~next_data1;
		crc = CRC_INIT;
		fill = '0;
	endfunction

	function automatic void close_packet();
		logic [15:0] c;
		c = ~crc;
		emit(c[7:0], KIND_CRC, 1'b0);
		emit(c[15:8], KIND_CRC, 1'b1);
		crc = CRC_INIT;
		fill = '0;
	endfunction

	function automatic void predict_packets(input logic [1:0] func, input logic [7:0] b,
		input logic last, input logic rx1);
		logic [6:0] lim;
		logic       full;
		if (max_pkt == 7'd0) begin
			lim = 7'd1;
		end else if (max_pkt > PACKET_LIMIT) begin
			lim = PACKET_LIMIT;
		end else begin
			lim = max_pkt;
		end
		case (usbdp_func_t'(func))
			FUNC_BYTE: begin
				if (fill == 7'd0) begin
					open_packet();
				end
				emit(b, KIND_DATA, 1'b0);
				crc = crc16_update(crc, b);
				fill = fill + 7'd1;
				full = (fill >= lim);
				if (full || last) begin
					close_packet();
				end
				if (full && last) begin
					open_packet();
					close_packet();
				end
			end
			FUNC_RXPID: begin
				next_data1 = ~rx1;
			end
			FUNC_EMPTY: begin
				if (fill != 7'd0) begin
					close_packet();
				end
				open_packet();
				close_packet();
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wire_byte_t e;
		if (!arst_n) begin
			wire_bytes_q.delete();
			max_pkt = MAX_PACKET_RST;
			pid0 = DATA0_PID_RST;
			pid1 = DATA1_PID_RST;
			crc = CRC_INIT;
			fill = '0;
			next_data1 = 1'b0;
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (usbdp_reg_t'(paddr[3:2]))
					REG_MAX_PACKET: max_pkt = pwdata[6:0];
					REG_DATA0_PID:  pid0 = pwdata[7:0];
					REG_DATA1_PID:  pid1 = pwdata[7:0];
					default: begin
					end
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (wire_bytes_q.size() == 0) begin
					$error("unexpected transfer: out_byte=%h byte_kind=%0d end_of_packet=%b",
						out_ch.out_byte, out_ch.byte_kind, out_ch.end_of_packet);
					fail_count++;
				end else begin
					e = wire_bytes_q.pop_front();
					if (out_ch.out_byte !== e.value) begin
						$error("out_byte: expected %h, got %h", e.value, out_ch.out_byte);
						fail_count++;
					end
					if (out_ch.byte_kind !== e.kind) begin
						$error("byte_kind: expected %0d, got %0d", e.kind, out_ch.byte_kind);
						fail_count++;
					end
					if (out_ch.end_of_packet !== e.eop) begin
						$error("end_of_packet: expected %b, got %b", e.eop,
							out_ch.end_of_packet);
						fail_count++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				predict_packets(in_ch.func, in_ch.data_byte, in_ch.last_of_transfer,
					in_ch.received_data1);
			end
			pending_count = wire_bytes_q.size();
		end
	end

endmodule

[tb/tb_usb_data_packetizer_crc16.sv]
`timescale 1ns / 100ps
// Top of the USB data packetizer testbench: clock, reset, stimulus, verdict.
// Needs usbdp_pkg, usbdp_if, the RTL and usbdp_checker.
module tb_usb_data_packetizer_crc16;
	import usbdp_pkg::*;

	localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 12;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending_count;
	int          idle_cycles;
	int          src_calm;
	int          sink_calm;

	usbdp_in_if  in_ch();
	usbdp_out_if out_ch();

	usb_data_packetizer_crc16 u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	usbdp_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_wait(ref int calm);
		int w;
		w = 0;
		if (calm > 0) begin
			calm--;
		end else if ($urandom_range(0, 11) == 0) begin
			calm = $urandom_range(10, 40);
		end else begin
			w = $urandom_range(0, 13);
		end
		return w;
	endfunction

	task automatic send_item(input logic [1:0] func, input logic [7:0] b, input logic last,
		input logic rx1);
		int w;
		w = pick_wait(src_calm);
		repeat (w) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.func <= func;
		in_ch.data_byte <= b;
		in_ch.last_of_transfer <= last;
		in_ch.received_data1 <= rx1;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic apb_write(input usbdp_reg_t r, input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait (pending_count == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(input logic [6:0] max_pkt, input logic [7:0] p0,
		input logic [7:0] p1);
		drain();
		apb_write(REG_MAX_PACKET, {25'd0, max_pkt});
		apb_write(REG_DATA0_PID, {24'd0, p0});
		apb_write(REG_DATA1_PID, {24'd0, p1});
	endtask

	task automatic random_traffic(input int n_items, input logic [6:0] max_pkt);
		int  sent;
		int  len;
		int  lim;
		int  r;
		logic cut;
		sent = 0;
		lim = (max_pkt == 7'd0) ? 1 : ((max_pkt > PACKET_LIMIT) ? int'(PACKET_LIMIT)
			: int'(max_pkt));
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				send_item(FUNC_RXPID, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				sent++;
			end else if (r < 9) begin
				send_item(FUNC_UNKNOWN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else if (r < 14) begin
				send_item(FUNC_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				sent++;
			end else begin
				case ($urandom_range(0, 3))
					0: len = lim * $urandom_range(1, 2);
					1: len = $urandom_range(1, 3);
					default: len = $urandom_range(1, 2 * lim + 1);
				endcase
				if (len > n_items - sent) begin
					len = n_items - sent;
				end
				cut = ($urandom_range(0, 9) == 0);
				for (int k = 0; k < len; k++) begin
					send_item(FUNC_BYTE, 8'($urandom_range(0, 255)),
						(k == len - 1) && !cut, 1'($urandom_range(0, 1)));
					sent++;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
			|| (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int w;
		out_ch.ready = 1'b0;
		forever begin
			w = pick_wait(sink_calm);
			repeat (w) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
			end
			@(negedge clk);
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	initial begin
		src_calm = 0;
		sink_calm = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_BYTE;
		in_ch.data_byte = '0;
		in_ch.last_of_transfer = 1'b0;
		in_ch.received_data1 = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_item(FUNC_EMPTY, 8'h00, 1'b0, 1'b0);
		send_item(FUNC_BYTE, 8'h00, 1'b0, 1'b0);
		send_item(FUNC_BYTE, 8'hFF, 1'b0, 1'b1);
		send_item(FUNC_BYTE, 8'hA5, 1'b1, 1'b0);
		send_item(FUNC_RXPID, 8'hFF, 1'b1, 1'b0);
		send_item(FUNC_BYTE, 8'h3C, 1'b1, 1'b0);
		send_item(FUNC_RXPID, 8'h00, 1'b0, 1'b1);
		send_item(FUNC_UNKNOWN, 8'hFF, 1'b1, 1'b1);
		for (int k = 1; k <= 8; k++) begin
			send_item(FUNC_BYTE, 8'(k * 37), k == 8, 1'b0);
		end
		send_item(FUNC_BYTE, 8'h80, 1'b0, 1'b0);
		send_item(FUNC_EMPTY, 8'h55, 1'b1, 1'b1);
		send_item(FUNC_BYTE, 8'h01, 1'b0, 1'b0);
		send_item(FUNC_RXPID, 8'h00, 1'b0, 1'b1);
		send_item(FUNC_BYTE, 8'hFE, 1'b1, 1'b0);
		for (int k = 0; k < 5; k++) begin
			send_item(FUNC_BYTE, 8'(8'h11 * k), 1'b0, 1'b0);
		end
		drain();
		apb_write(REG_MAX_PACKET, 32'd2);
		send_item(FUNC_BYTE, 8'h7E, 1'b0, 1'b0);
		send_item(FUNC_BYTE, 8'h81, 1'b1, 1'b0);

		load_settings(7'd1, 8'h00, 8'hFF);
		random_traffic(60, 7'd1);
		load_settings(7'd64, 8'hFF, 8'h00);
		random_traffic(70, 7'd64);
		load_settings(7'd0, DATA0_PID_RST, DATA1_PID_RST);
		random_traffic(50, 7'd0);
		load_settings(7'd127, 8'h5A, 8'hA5);
		random_traffic(60, 7'd127);
		load_settings(7'd3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		random_traffic(70, 7'd3);
		begin
			logic [6:0] mp;
			mp = 7'($urandom_range(1, 16));
			load_settings(mp, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			random_traffic(70, mp);
		end

		drain();
		if (fail_count == 0 && pending_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
design/usbdp_pkg.sv
design/usbdp_if.sv
design/usbdp_front.sv
design/usbdp_fifo.sv
design/usbdp_back.sv
design/usb_data_packetizer_crc16.sv
tb/usbdp_checker.sv
tb/tb_usb_data_packetizer_crc16.sv
